>>> hdl/aabb_affine_transform_unit_assert.svh
// Assertion macros shared by the box transform RTL.
`ifndef AABB_AFFINE_TRANSFORM_UNIT_ASSERT_SVH
`define AABB_AFFINE_TRANSFORM_UNIT_ASSERT_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define AAT_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside reset.
`define AAT_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/aat_pkg.sv
// Shared constants and types of the box transform unit.
`default_nettype none
package aat_pkg;

    localparam int COORD_WIDTH    = 24;
    localparam int COEF_FRAC_BITS = 14;
    localparam int COEF_WIDTH     = 16;
    localparam int AXES           = 3;
    localparam int ROW_WIDTH      = AXES * COEF_WIDTH;
    localparam int CFG_DATA_WIDTH = ROW_WIDTH;
    localparam int CFG_IDX_WIDTH  = 3;
    localparam int PIPE_STAGES    = 5;

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        REG_MATRIX_ROW0 = 3'd0,
        REG_MATRIX_ROW1 = 3'd1,
        REG_MATRIX_ROW2 = 3'd2,
        REG_TRANSLATE_X = 3'd3,
        REG_TRANSLATE_Y = 3'd4,
        REG_TRANSLATE_Z = 3'd5
    } t_cfg_reg;

endpackage
`default_nettype wire

>>> hdl/aat_box_if.sv
// Input channel carrying one box as its lower and upper corners.
`default_nettype none
interface aat_box_if #(
    parameter int COORD_WIDTH = aat_pkg::COORD_WIDTH
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] lo_x;
    logic signed [COORD_WIDTH-1:0] lo_y;
    logic signed [COORD_WIDTH-1:0] lo_z;
    logic signed [COORD_WIDTH-1:0] hi_x;
    logic signed [COORD_WIDTH-1:0] hi_y;
    logic signed [COORD_WIDTH-1:0] hi_z;

    modport source (output valid, lo_x, lo_y, lo_z, hi_x, hi_y, hi_z, input ready);
    modport sink (input valid, lo_x, lo_y, lo_z, hi_x, hi_y, hi_z, output ready);
endinterface
`default_nettype wire

>>> hdl/aat_result_if.sv
// Output channel carrying one transformed bounding box and its saturation flag.
`default_nettype none
interface aat_result_if #(
    parameter int COORD_WIDTH = aat_pkg::COORD_WIDTH
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] out_lo_x;
    logic signed [COORD_WIDTH-1:0] out_lo_y;
    logic signed [COORD_WIDTH-1:0] out_lo_z;
    logic signed [COORD_WIDTH-1:0] out_hi_x;
    logic signed [COORD_WIDTH-1:0] out_hi_y;
    logic signed [COORD_WIDTH-1:0] out_hi_z;
    logic                          saturated;

    modport source (output valid, out_lo_x, out_lo_y, out_lo_z, out_hi_x, out_hi_y,
                    out_hi_z, saturated, input ready);
    modport sink (input valid, out_lo_x, out_lo_y, out_lo_z, out_hi_x, out_hi_y,
                  out_hi_z, saturated, output ready);
endinterface
`default_nettype wire

>>> hdl/aabb_affine_transform_unit.sv
// Top level of the pipelined axis-aligned box transform unit.
//
// Usage: a box arrives on i_box as lower and upper corners and leaves on o_box as the
// axis-aligned box that bounds it after the configured 3x3 map and translation.
// The configuration port writes one register per cycle while i_cfg_we is high; it must
// only be written while no item is in flight.
// The pipeline has five register stages: product, min/max select, partial sums, final
// sum with rounding shift, and clamp into the output register; o_box.valid is the valid
// bit of that last stage.
// One item per cycle passes unless a full pipeline is held by o_box.ready low; the nine
// coefficient multipliers per corner and the adder stages each take one item per cycle.
// Every stage holds its own valid bit and advances when the stage after it is empty or
// advancing, so bubbles are squeezed out while the receiver stalls and i_box.ready
// stays high unless all five stages are full and o_box.ready is low.
// Synchronous reset empties the pipeline and restores the identity matrix and a zero
// translation.
// Lower bounds round toward minus infinity and upper bounds toward plus infinity;
// any bound outside the coordinate range is clamped and sets saturated.
`default_nettype none
`include "aabb_affine_transform_unit_assert.svh"
module aabb_affine_transform_unit #(
    parameter int COORD_WIDTH    = aat_pkg::COORD_WIDTH,
    parameter int COEF_FRAC_BITS = aat_pkg::COEF_FRAC_BITS
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_cfg_we,
    input  wire logic [aat_pkg::CFG_IDX_WIDTH-1:0]    i_cfg_idx,
    input  wire logic [aat_pkg::CFG_DATA_WIDTH-1:0]   i_cfg_data,
    aat_box_if.sink                                   i_box,
    aat_result_if.source                              o_box
);

    localparam int CW   = COORD_WIDTH;
    localparam int FRAC = COEF_FRAC_BITS;
    localparam int CF   = aat_pkg::COEF_WIDTH;
    localparam int AX   = aat_pkg::AXES;
    localparam int RW   = aat_pkg::ROW_WIDTH;
    localparam int NS   = aat_pkg::PIPE_STAGES;
    localparam int PW   = CW + CF;
    localparam int TW   = CW + FRAC;
    localparam int SW   = ((TW > PW) ? TW : PW) + 2;
    localparam int QW   = SW - FRAC;

    localparam logic [CF-1:0]        COEF_ONE = CF'(64'd1 << FRAC);
    localparam logic signed [QW-1:0] Q_MAX    = {{(QW-CW+1){1'b0}}, {(CW-1){1'b1}}};
    localparam logic signed [QW-1:0] Q_MIN    = {{(QW-CW+1){1'b1}}, {(CW-1){1'b0}}};
    localparam logic signed [CW-1:0] OUT_MAX  = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] OUT_MIN  = {1'b1, {(CW-1){1'b0}}};

    logic [RW-1:0]        r_row   [AX];
    logic signed [CW-1:0] r_trans [AX];

    logic [NS-1:0] r_v;
    logic [NS-1:0] adv;

    logic signed [CW-1:0] box_lo [AX];
    logic signed [CW-1:0] box_hi [AX];

    logic signed [PW-1:0] n_prod_lo [AX][AX];
    logic signed [PW-1:0] n_prod_hi [AX][AX];
    logic signed [PW-1:0] r_prod_lo [AX][AX];
    logic signed [PW-1:0] r_prod_hi [AX][AX];

    logic signed [PW-1:0] n_min [AX][AX];
    logic signed [PW-1:0] n_max [AX][AX];
    logic signed [PW-1:0] r_min [AX][AX];
    logic signed [PW-1:0] r_max [AX][AX];

    logic signed [SW-1:0] n_sum_lo_a [AX];
    logic signed [SW-1:0] n_sum_lo_b [AX];
    logic signed [SW-1:0] n_sum_hi_a [AX];
    logic signed [SW-1:0] n_sum_hi_b [AX];
    logic signed [SW-1:0] r_sum_lo_a [AX];
    logic signed [SW-1:0] r_sum_lo_b [AX];
    logic signed [SW-1:0] r_sum_hi_a [AX];
    logic signed [SW-1:0] r_sum_hi_b [AX];

    logic signed [QW-1:0] n_q_lo [AX];
    logic signed [QW-1:0] n_q_hi [AX];
    logic signed [QW-1:0] r_q_lo [AX];
    logic signed [QW-1:0] r_q_hi [AX];

    logic signed [CW-1:0] n_out_lo [AX];
    logic signed [CW-1:0] n_out_hi [AX];
    logic                 n_sat;
    logic signed [CW-1:0] r_out_lo [AX];
    logic signed [CW-1:0] r_out_hi [AX];
    logic                 r_sat;

    logic                 bounds_ordered;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < AX; i++) begin
                r_row[i]   <= RW'(COEF_ONE) << (CF * i);
                r_trans[i] <= '0;
            end
        end else if (i_cfg_we) begin
            unique case (aat_pkg::t_cfg_reg'(i_cfg_idx))
                aat_pkg::REG_MATRIX_ROW0: r_row[0]   <= i_cfg_data[RW-1:0];
                aat_pkg::REG_MATRIX_ROW1: r_row[1]   <= i_cfg_data[RW-1:0];
                aat_pkg::REG_MATRIX_ROW2: r_row[2]   <= i_cfg_data[RW-1:0];
                aat_pkg::REG_TRANSLATE_X: r_trans[0] <= $signed(i_cfg_data[CW-1:0]);
                aat_pkg::REG_TRANSLATE_Y: r_trans[1] <= $signed(i_cfg_data[CW-1:0]);
                aat_pkg::REG_TRANSLATE_Z: r_trans[2] <= $signed(i_cfg_data[CW-1:0]);
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        adv[NS-1] = !r_v[NS-1] || o_box.ready;
        for (int k = NS - 2; k >= 0; k--) begin
            adv[k] = !r_v[k] || adv[k+1];
        end
    end

    assign i_box.ready = adv[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (adv[0]) begin
                r_v[0] <= i_box.valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (adv[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    assign box_lo[0] = i_box.lo_x;
    assign box_lo[1] = i_box.lo_y;
    assign box_lo[2] = i_box.lo_z;
    assign box_hi[0] = i_box.hi_x;
    assign box_hi[1] = i_box.hi_y;
    assign box_hi[2] = i_box.hi_z;

    // Stage 1: products of every coefficient with both corners of its input axis.
    always_comb begin
        logic signed [CF-1:0] coef;
        coef = '0;
        for (int i = 0; i < AX; i++) begin
            for (int j = 0; j < AX; j++) begin
                coef            = $signed(r_row[i][CF*j +: CF]);
                n_prod_lo[i][j] = PW'(coef) * PW'(box_lo[i]);
                n_prod_hi[i][j] = PW'(coef) * PW'(box_hi[i]);
            end
        end
    end

    // Stage 2: order each product pair.
    always_comb begin
        for (int i = 0; i < AX; i++) begin
            for (int j = 0; j < AX; j++) begin
                if (r_prod_lo[i][j] < r_prod_hi[i][j]) begin
                    n_min[i][j] = r_prod_lo[i][j];
                    n_max[i][j] = r_prod_hi[i][j];
                end else begin
                    n_min[i][j] = r_prod_hi[i][j];
                    n_max[i][j] = r_prod_lo[i][j];
                end
            end
        end
    end

    // Stage 3: partial sums. The upper bound's translation carries the ceiling offset.
    always_comb begin
        logic signed [TW-1:0] t_lo;
        logic signed [TW-1:0] t_hi;
        t_lo = '0;
        t_hi = '0;
        for (int j = 0; j < AX; j++) begin
            t_lo          = $signed({r_trans[j], {FRAC{1'b0}}});
            t_hi          = $signed({r_trans[j], {FRAC{1'b1}}});
            n_sum_lo_a[j] = SW'(t_lo) + SW'(r_min[0][j]);
            n_sum_lo_b[j] = SW'(r_min[1][j]) + SW'(r_min[2][j]);
            n_sum_hi_a[j] = SW'(t_hi) + SW'(r_max[0][j]);
            n_sum_hi_b[j] = SW'(r_max[1][j]) + SW'(r_max[2][j]);
        end
    end

    // Stage 4: final sums, dropping the fraction bits rounds toward minus infinity.
    always_comb begin
        logic signed [SW-1:0] tot_lo;
        logic signed [SW-1:0] tot_hi;
        tot_lo = '0;
        tot_hi = '0;
        for (int j = 0; j < AX; j++) begin
            tot_lo    = r_sum_lo_a[j] + r_sum_lo_b[j];
            tot_hi    = r_sum_hi_a[j] + r_sum_hi_b[j];
            n_q_lo[j] = tot_lo[SW-1:FRAC];
            n_q_hi[j] = tot_hi[SW-1:FRAC];
        end
    end

    // Stage 5: clamp into the coordinate range.
    always_comb begin
        n_sat = 1'b0;
        for (int j = 0; j < AX; j++) begin
            if (r_q_lo[j] > Q_MAX) begin
                n_out_lo[j] = OUT_MAX;
                n_sat       = 1'b1;
            end else if (r_q_lo[j] < Q_MIN) begin
                n_out_lo[j] = OUT_MIN;
                n_sat       = 1'b1;
            end else begin
                n_out_lo[j] = r_q_lo[j][CW-1:0];
            end
            if (r_q_hi[j] > Q_MAX) begin
                n_out_hi[j] = OUT_MAX;
                n_sat       = 1'b1;
            end else if (r_q_hi[j] < Q_MIN) begin
                n_out_hi[j] = OUT_MIN;
                n_sat       = 1'b1;
            end else begin
                n_out_hi[j] = r_q_hi[j][CW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_prod_lo <= n_prod_lo;
            r_prod_hi <= n_prod_hi;
        end
        if (adv[1]) begin
            r_min <= n_min;
            r_max <= n_max;
        end
        if (adv[2]) begin
            r_sum_lo_a <= n_sum_lo_a;
            r_sum_lo_b <= n_sum_lo_b;
            r_sum_hi_a <= n_sum_hi_a;
            r_sum_hi_b <= n_sum_hi_b;
        end
        if (adv[3]) begin
            r_q_lo <= n_q_lo;
            r_q_hi <= n_q_hi;
        end
        if (adv[4]) begin
            r_out_lo <= n_out_lo;
            r_out_hi <= n_out_hi;
            r_sat    <= n_sat;
        end
    end

    assign o_box.valid     = r_v[NS-1];
    assign o_box.out_lo_x  = r_out_lo[0];
    assign o_box.out_lo_y  = r_out_lo[1];
    assign o_box.out_lo_z  = r_out_lo[2];
    assign o_box.out_hi_x  = r_out_hi[0];
    assign o_box.out_hi_y  = r_out_hi[1];
    assign o_box.out_hi_z  = r_out_hi[2];
    assign o_box.saturated = r_sat;

    assign bounds_ordered = (o_box.out_lo_x <= o_box.out_hi_x)
                         && (o_box.out_lo_y <= o_box.out_hi_y)
                         && (o_box.out_lo_z <= o_box.out_hi_z);

    `AAT_ASSERT_NOW(a_bounds_ordered, o_box.valid, bounds_ordered, "Lower bound exceeds upper bound.")
    `AAT_ASSERT_NEXT(a_last_stage_fill, r_v[NS-2] && adv[NS-1], r_v[NS-1], "Item lost entering the output register.")
    `AAT_ASSERT_NOW(a_empty_accepts, r_v == '0, i_box.ready, "Empty pipeline refuses an item.")

endmodule
`default_nettype wire

>>> tb/tb.sv
// Self-checking testbench of the axis-aligned box transform unit.
module tb;

    localparam int COORD_WIDTH    = aat_pkg::COORD_WIDTH;
    localparam int COEF_FRAC_BITS = aat_pkg::COEF_FRAC_BITS;
    localparam int COEF_WIDTH     = aat_pkg::COEF_WIDTH;
    localparam int AXES           = aat_pkg::AXES;
    localparam int ROW_WIDTH      = aat_pkg::ROW_WIDTH;
    localparam int CFG_DATA_WIDTH = aat_pkg::CFG_DATA_WIDTH;
    localparam int CFG_IDX_WIDTH  = aat_pkg::CFG_IDX_WIDTH;
    localparam int PIPE_STAGES    = aat_pkg::PIPE_STAGES;

    localparam longint COORD_MAX = (longint'(1) <<< (COORD_WIDTH - 1)) - 1;
    localparam longint COORD_MIN = -COORD_MAX - 1;
    localparam int CMAX = int'(COORD_MAX);
    localparam int CMIN = -CMAX - 1;
    localparam logic [COORD_WIDTH-1:0] EDGE_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic [COORD_WIDTH-1:0] EDGE_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    localparam logic [COEF_WIDTH-1:0] COEF_ONE = COEF_WIDTH'(1 << COEF_FRAC_BITS);
    localparam logic [COEF_WIDTH-1:0] COEF_NEG_ONE = -COEF_ONE;
    localparam logic [COEF_WIDTH-1:0] COEF_HALF = COEF_ONE >> 1;
    localparam logic [COEF_WIDTH-1:0] COEF_MAX = {1'b0, {(COEF_WIDTH-1){1'b1}}};
    localparam logic [COEF_WIDTH-1:0] COEF_MIN = {1'b1, {(COEF_WIDTH-1){1'b0}}};
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_IDX_UNUSED_LO = 3'd6;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_IDX_UNUSED_HI = 3'd7;
    localparam int RANDOM_BOXES = 1400;
    localparam int LONG_HOLD = 80;
    localparam int STALL_LIMIT = 2000;

    typedef struct packed {
        logic [AXES-1:0][COORD_WIDTH-1:0] lo;
        logic [AXES-1:0][COORD_WIDTH-1:0] hi;
    } t_corners;

    typedef struct packed {
        logic [AXES-1:0][COORD_WIDTH-1:0] lo;
        logic [AXES-1:0][COORD_WIDTH-1:0] hi;
        logic                             sat;
    } t_bounds;

    typedef enum int {SET_RESET, SET_NEGATE, SET_HALF, SET_CLAMP, SET_MIXED} t_setting;

    typedef struct packed {
        t_setting setting;
        int       lx, ly, lz, hx, hy, hz;
        bit       fixed;
        int       olx, oly, olz, ohx, ohy, ohz;
        bit       osat;
    } t_dir_row;

    t_dir_row dir_rows [21] = '{
        '{SET_RESET, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0},
        '{SET_RESET, -256, -512, -768, 256, 512, 768,
          1, -256, -512, -768, 256, 512, 768, 0},
        '{SET_RESET, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX,
          1, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, 0},
        '{SET_RESET, 1000, -5, CMAX, -1000, 5, CMIN,
          1, -1000, -5, CMIN, 1000, 5, CMAX, 0},
        '{SET_RESET, 123456, -654321, 42, 2345678, -1, 99999, 0, 0, 0, 0, 0, 0, 0, 0},
        '{SET_NEGATE, 100, 200, 300, 400, 500, 600,
          1, -400, -500, -600, -100, -200, -300, 0},
        '{SET_NEGATE, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN,
          1, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, 1},
        '{SET_NEGATE, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX,
          1, -CMAX, -CMAX, -CMAX, -CMAX, -CMAX, -CMAX, 0},
        '{SET_NEGATE, -7, 3, 0, 11, 3, -2, 0, 0, 0, 0, 0, 0, 0, 0},
        '{SET_HALF, 1, -1, 3, 1, -1, 3, 1, 0, -1, 1, 1, 0, 2, 0},
        '{SET_HALF, 2, 4, -6, 8, 10, -2, 1, 1, 2, -3, 4, 5, -1, 0},
        '{SET_HALF, CMIN, -3, 5, CMAX, 7, -9, 0, 0, 0, 0, 0, 0, 0, 0},
        '{SET_CLAMP, 0, 0, 0, 0, 0, 0, 1, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, 0},
        '{SET_CLAMP, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX,
          1, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, 1},
        '{SET_CLAMP, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN,
          1, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, 1},
        '{SET_CLAMP, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX,
          1, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, 1},
        '{SET_CLAMP, 1, 2, 3, 4, 5, 6, 0, 0, 0, 0, 0, 0, 0, 0},
        '{SET_MIXED, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, 0, 0, 0, 0, 0, 0, 0, 0},
        '{SET_MIXED, -1, -1, -1, 1, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0},
        '{SET_MIXED, 3000, -70000, 512, 3001, 80000, 511, 0, 0, 0, 0, 0, 0, 0, 0},
        '{SET_MIXED, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}
    };

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_cfg_we;
    logic [CFG_IDX_WIDTH-1:0]   i_cfg_idx;
    logic [CFG_DATA_WIDTH-1:0]  i_cfg_data;

    aat_box_if    box_if ();
    aat_result_if res_if ();

    aabb_affine_transform_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_box      (box_if),
        .o_box      (res_if)
    );

    logic [AXES-1:0][ROW_WIDTH-1:0]   mat_rows;
    logic [AXES-1:0][COORD_WIDTH-1:0] shift_xyz;
    t_bounds pending_bounds [$];
    bit      fixed_want;
    t_bounds fixed_bounds;
    int      errors;
    int      boxes_taken;
    int      bounds_checked;
    int      clamped_seen;
    int      settings_loaded;
    int      hold_requests;
    int      quiet_cycles;

    string lo_names [AXES] = '{"out_lo_x", "out_lo_y", "out_lo_z"};
    string hi_names [AXES] = '{"out_hi_x", "out_hi_y", "out_hi_z"};

    function automatic bit clamp_coord(input longint v, output logic [COORD_WIDTH-1:0] q);
        if (v > COORD_MAX) begin
            q = EDGE_MAX;
            return 1'b1;
        end
        if (v < COORD_MIN) begin
            q = EDGE_MIN;
            return 1'b1;
        end
        q = COORD_WIDTH'(v);
        return 1'b0;
    endfunction

    function automatic t_bounds transform_box(input t_corners b);
        t_bounds r;
        longint  base, lo_acc, hi_acc, m, pa, pb;
        r.sat = 1'b0;
        for (int j = 0; j < AXES; j++) begin
            base = longint'($signed(shift_xyz[j])) <<< COEF_FRAC_BITS;
            lo_acc = base;
            hi_acc = base;
            for (int i = 0; i < AXES; i++) begin
                m  = longint'($signed(mat_rows[i][COEF_WIDTH*j +: COEF_WIDTH]));
                pa = m * longint'($signed(b.lo[i]));
                pb = m * longint'($signed(b.hi[i]));
                lo_acc += (pa < pb) ? pa : pb;
                hi_acc += (pa < pb) ? pb : pa;
            end
            r.sat |= clamp_coord(lo_acc >>> COEF_FRAC_BITS, r.lo[j]);
            r.sat |= clamp_coord((hi_acc + (longint'(1) <<< COEF_FRAC_BITS) - 1)
                                 >>> COEF_FRAC_BITS, r.hi[j]);
        end
        return r;
    endfunction

    function automatic logic [COORD_WIDTH-1:0] pick_coord();
        case ($urandom_range(0, 9))
            0: return EDGE_MIN;
            1: return EDGE_MAX;
            2, 3: return COORD_WIDTH'($urandom_range(0, 4095)) - COORD_WIDTH'(2048);
            4, 5, 6: return COORD_WIDTH'($urandom_range(0, 1 << 18)) - COORD_WIDTH'(1 << 17);
            default: return COORD_WIDTH'($urandom());
        endcase
    endfunction

    function automatic t_corners pick_box();
        t_corners                b;
        logic [COORD_WIDTH-1:0]  u, v;
        int                      shape;
        shape = $urandom_range(0, 19);
        for (int i = 0; i < AXES; i++) begin
            u = pick_coord();
            v = pick_coord();
            if (shape < 14) begin
                b.lo[i] = ($signed(u) > $signed(v)) ? v : u;
                b.hi[i] = ($signed(u) > $signed(v)) ? u : v;
            end else if (shape < 17) begin
                b.lo[i] = u;
                b.hi[i] = u;
            end else begin
                b.lo[i] = u;
                b.hi[i] = v;
            end
        end
        return b;
    endfunction

    function automatic logic [COEF_WIDTH-1:0] pick_coef();
        case ($urandom_range(0, 9))
            0: return COEF_MAX;
            1: return COEF_MIN;
            2: return COEF_ONE;
            3: return COEF_NEG_ONE;
            4: return '0;
            5, 6: return COEF_WIDTH'($urandom_range(0, 4095)) - COEF_WIDTH'(2048);
            default: return COEF_WIDTH'($urandom());
        endcase
    endfunction

    function automatic logic [CFG_DATA_WIDTH-1:0] pick_shift();
        logic [COORD_WIDTH-1:0] t;
        case ($urandom_range(0, 5))
            0: t = EDGE_MAX;
            1: t = EDGE_MIN;
            2: t = '0;
            3: t = COORD_WIDTH'($urandom_range(0, 1 << 16)) - COORD_WIDTH'(1 << 15);
            default: t = COORD_WIDTH'($urandom());
        endcase
        return {(CFG_DATA_WIDTH-COORD_WIDTH)'($urandom()), t};
    endfunction

    task automatic write_reg(input logic [CFG_IDX_WIDTH-1:0] idx,
                             input logic [CFG_DATA_WIDTH-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            aat_pkg::REG_MATRIX_ROW0: mat_rows[0] = data;
            aat_pkg::REG_MATRIX_ROW1: mat_rows[1] = data;
            aat_pkg::REG_MATRIX_ROW2: mat_rows[2] = data;
            aat_pkg::REG_TRANSLATE_X: shift_xyz[0] = data[COORD_WIDTH-1:0];
            aat_pkg::REG_TRANSLATE_Y: shift_xyz[1] = data[COORD_WIDTH-1:0];
            aat_pkg::REG_TRANSLATE_Z: shift_xyz[2] = data[COORD_WIDTH-1:0];
            default: ;
        endcase
    endtask

    task automatic load_transform(input logic [AXES-1:0][CFG_DATA_WIDTH-1:0] rows,
                                  input logic [AXES-1:0][CFG_DATA_WIDTH-1:0] shifts);
        write_reg(aat_pkg::REG_MATRIX_ROW0, rows[0]);
        write_reg(aat_pkg::REG_MATRIX_ROW1, rows[1]);
        write_reg(CFG_IDX_UNUSED_LO, CFG_DATA_WIDTH'({$urandom(), $urandom()}));
        write_reg(aat_pkg::REG_MATRIX_ROW2, rows[2]);
        write_reg(aat_pkg::REG_TRANSLATE_X, shifts[0]);
        write_reg(CFG_IDX_UNUSED_HI, CFG_DATA_WIDTH'({$urandom(), $urandom()}));
        write_reg(aat_pkg::REG_TRANSLATE_Y, shifts[1]);
        write_reg(aat_pkg::REG_TRANSLATE_Z, shifts[2]);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        settings_loaded++;
    endtask

    task automatic load_setting(input t_setting s);
        logic [AXES-1:0][CFG_DATA_WIDTH-1:0] rows, shifts;
        logic [COEF_WIDTH-1:0]               diag;
        rows = '0;
        shifts = '0;
        case (s)
            SET_NEGATE: diag = COEF_NEG_ONE;
            SET_HALF:   diag = COEF_HALF;
            default:    diag = COEF_ONE;
        endcase
        for (int k = 0; k < AXES; k++) rows[k][COEF_WIDTH*k +: COEF_WIDTH] = diag;
        if (s == SET_CLAMP) begin
            for (int k = 0; k < AXES; k++) begin
                rows[k] = {AXES{COEF_MIN}};
                shifts[k] = {{(CFG_DATA_WIDTH-COORD_WIDTH){1'b1}}, EDGE_MAX};
            end
        end else if (s == SET_MIXED) begin
            rows[0] = {COEF_MAX, COEF_MIN, 16'h0001};
            rows[1] = {16'hFFFF, COEF_HALF, COEF_NEG_ONE};
            rows[2] = {16'h0000, COEF_MAX, 16'hE000};
            shifts[0] = {{(CFG_DATA_WIDTH-COORD_WIDTH){1'b1}}, EDGE_MIN};
            shifts[1] = CFG_DATA_WIDTH'(1);
            shifts[2] = '1;
        end
        load_transform(rows, shifts);
    endtask

    task automatic offer_box(input t_corners b, input bit fixed, input t_bounds want);
        @(negedge i_clk);
        box_if.valid <= 1'b1;
        box_if.lo_x  <= b.lo[0];
        box_if.lo_y  <= b.lo[1];
        box_if.lo_z  <= b.lo[2];
        box_if.hi_x  <= b.hi[0];
        box_if.hi_y  <= b.hi[1];
        box_if.hi_z  <= b.hi[2];
        fixed_want   = fixed;
        fixed_bounds = want;
        do @(posedge i_clk); while (!box_if.ready);
    endtask

    task automatic idle_cycles(input int n);
        repeat (n) begin
            @(negedge i_clk);
            box_if.valid <= 1'b0;
        end
    endtask

    task automatic drain();
        @(negedge i_clk);
        box_if.valid <= 1'b0;
        while (pending_bounds.size() != 0) @(posedge i_clk);
        repeat (PIPE_STAGES + 2) @(posedge i_clk);
    endtask

    task automatic check_coord(input string name, input logic [COORD_WIDTH-1:0] want,
                               input logic [COORD_WIDTH-1:0] got);
        if (got !== want) begin
            errors++;
            $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin : result_sink
        int run_len;
        int stall_pct;
        int holds_done;
        holds_done = 0;
        res_if.ready = 1'b0;
        forever begin
            if (hold_requests != holds_done) begin
                holds_done++;
                repeat (LONG_HOLD) begin
                    @(negedge i_clk);
                    res_if.ready <= 1'b0;
                end
            end else begin
                run_len = $urandom_range(8, 60);
                stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 80);
                repeat (run_len) begin
                    @(negedge i_clk);
                    res_if.ready <= ($urandom_range(1, 100) > stall_pct);
                end
            end
        end
    end

    always @(posedge i_clk) begin : scoreboard
        t_corners seen;
        t_bounds  got, want;
        bit       moved;
        moved = 1'b0;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            moved = 1'b1;
            got.lo = {res_if.out_lo_z, res_if.out_lo_y, res_if.out_lo_x};
            got.hi = {res_if.out_hi_z, res_if.out_hi_y, res_if.out_hi_x};
            got.sat = res_if.saturated;
            bounds_checked++;
            if (got.sat) clamped_seen++;
            if (pending_bounds.size() == 0) begin
                errors++;
                $error("result item arrived with no box outstanding");
            end else begin
                want = pending_bounds.pop_front();
                for (int k = 0; k < AXES; k++) begin
                    check_coord(lo_names[k], want.lo[k], got.lo[k]);
                    check_coord(hi_names[k], want.hi[k], got.hi[k]);
                end
                if (got.sat !== want.sat) begin
                    errors++;
                    $error("saturated: expected %0d, got %0d", want.sat, got.sat);
                end
            end
        end
        if (i_rst_n && box_if.valid && box_if.ready) begin
            moved = 1'b1;
            seen.lo = {box_if.lo_z, box_if.lo_y, box_if.lo_x};
            seen.hi = {box_if.hi_z, box_if.hi_y, box_if.hi_x};
            pending_bounds.push_back(fixed_want ? fixed_bounds : transform_box(seen));
            boxes_taken++;
        end
        quiet_cycles = (moved || !i_rst_n) ? 0 : quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    initial begin : stimulus
        t_setting current;
        t_corners b;
        t_bounds  w;
        t_dir_row r;
        logic [AXES-1:0][CFG_DATA_WIDTH-1:0] rows, shifts;
        int random_sent, phase, phase_len, sent_in_phase, burst;
        errors = 0;
        boxes_taken = 0;
        bounds_checked = 0;
        clamped_seen = 0;
        settings_loaded = 0;
        hold_requests = 0;
        quiet_cycles = 0;
        fixed_want = 1'b0;
        fixed_bounds = '0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        box_if.valid = 1'b0;
        box_if.lo_x = '0;
        box_if.lo_y = '0;
        box_if.lo_z = '0;
        box_if.hi_x = '0;
        box_if.hi_y = '0;
        box_if.hi_z = '0;
        for (int k = 0; k < AXES; k++) begin
            mat_rows[k] = '0;
            mat_rows[k][COEF_WIDTH*k +: COEF_WIDTH] = COEF_ONE;
            shift_xyz[k] = '0;
        end
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        current = SET_RESET;
        foreach (dir_rows[n]) begin
            r = dir_rows[n];
            if (r.setting != current) begin
                drain();
                load_setting(r.setting);
                current = r.setting;
            end
            b.lo = {COORD_WIDTH'(r.lz), COORD_WIDTH'(r.ly), COORD_WIDTH'(r.lx)};
            b.hi = {COORD_WIDTH'(r.hz), COORD_WIDTH'(r.hy), COORD_WIDTH'(r.hx)};
            w.lo = {COORD_WIDTH'(r.olz), COORD_WIDTH'(r.oly), COORD_WIDTH'(r.olx)};
            w.hi = {COORD_WIDTH'(r.ohz), COORD_WIDTH'(r.ohy), COORD_WIDTH'(r.ohx)};
            w.sat = r.osat;
            offer_box(b, r.fixed, w);
            if ($urandom_range(0, 3) == 0) idle_cycles($urandom_range(1, 3));
        end

        random_sent = 0;
        phase = 0;
        while (random_sent < RANDOM_BOXES) begin
            drain();
            for (int k = 0; k < AXES; k++) begin
                rows[k] = {pick_coef(), pick_coef(), pick_coef()};
                shifts[k] = pick_shift();
            end
            load_transform(rows, shifts);
            phase_len = $urandom_range(40, 160);
            if (phase % 5 == 2) begin
                hold_requests++;
                phase_len = 300;
            end
            sent_in_phase = 0;
            while (sent_in_phase < phase_len) begin
                if (phase % 5 == 2 || $urandom_range(0, 4) == 0)
                    burst = $urandom_range(30, 80);
                else
                    burst = $urandom_range(1, 12);
                repeat (burst) offer_box(pick_box(), 1'b0, '0);
                sent_in_phase += burst;
                random_sent += burst;
                if (phase % 5 != 2 && $urandom_range(0, 5) != 0)
                    idle_cycles($urandom_range(1, 8));
            end
            phase++;
        end

        drain();
        repeat (4 * PIPE_STAGES) @(posedge i_clk);
        $display("Transformed %0d boxes under %0d register settings, %0d long output holds.",
                 boxes_taken, settings_loaded, hold_requests);
        $display("Checked %0d result items, %0d of them clamped.", bounds_checked, clamped_seen);
        if (errors == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end
endmodule
